[sv/forth_stack_alu_unit_macros.svh]
// Assertion shorthands shared by the stack ALU modules.
// Every property samples on the rising clock edge and is off while reset is low.
`ifndef FORTH_STACK_ALU_UNIT_MACROS_SVH
`define FORTH_STACK_ALU_UNIT_MACROS_SVH

// Condition must hold on every sampled edge.
`define FSA_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold on the same edge as the antecedent.
`define FSA_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold on the edge after the antecedent.
`define FSA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/fsa_pkg.sv]
package fsa_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;
	localparam int FRAC_W          = 16;
	localparam int FUNC_W          = 4;
	localparam int STS_W           = 2;
	localparam int KIND_W          = 2;
	localparam int SD_W            = 7;
	localparam int IN_TDATA_W      = DATA_W;
	localparam int IN_TUSER_W      = FUNC_W;
	localparam int OUT_TDATA_W     = 40;
	localparam int OUT_TUSER_W     = STS_W + KIND_W;

	// Word codes
	localparam logic [FUNC_W-1:0] FN_PUSH  = 4'd0;
	localparam logic [FUNC_W-1:0] FN_DUP   = 4'd1;
	localparam logic [FUNC_W-1:0] FN_DROP  = 4'd2;
	localparam logic [FUNC_W-1:0] FN_SWAP  = 4'd3;
	localparam logic [FUNC_W-1:0] FN_OVER  = 4'd4;
	localparam logic [FUNC_W-1:0] FN_ADD   = 4'd5;
	localparam logic [FUNC_W-1:0] FN_SUB   = 4'd6;
	localparam logic [FUNC_W-1:0] FN_MUL   = 4'd7;
	localparam logic [FUNC_W-1:0] FN_DIV   = 4'd8;
	localparam logic [FUNC_W-1:0] FN_DOT   = 4'd9;
	localparam logic [FUNC_W-1:0] FN_DEPTH = 4'd10;
	localparam logic [FUNC_W-1:0] FN_CLEAR = 4'd11;
	localparam logic [FUNC_W-1:0] FN_EMIT  = 4'd12;
	localparam logic [FUNC_W-1:0] FN_CR    = 4'd13;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK   = 2'd0;
	localparam logic [STS_W-1:0] STS_OVF  = 2'd1;
	localparam logic [STS_W-1:0] STS_UNF  = 2'd2;
	localparam logic [STS_W-1:0] STS_DIVZ = 2'd3;

	// Print kinds
	localparam logic [KIND_W-1:0] PK_NONE   = 2'd0;
	localparam logic [KIND_W-1:0] PK_NUMBER = 2'd1;
	localparam logic [KIND_W-1:0] PK_CHAR   = 2'd2;
	localparam logic [KIND_W-1:0] PK_LINE   = 2'd3;

	localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
	localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

	typedef enum logic [1:0] {
		ADDR_SP,
		ADDR_SP1,
		ADDR_SP2
	} fsa_waddr_t;

	typedef enum logic [3:0] {
		WS_LIT,
		WS_TOP,
		WS_SEC,
		WS_HELD,
		WS_ADD,
		WS_SUB,
		WS_MUL,
		WS_DIV,
		WS_DEPTH
	} fsa_wsrc_t;

	typedef enum logic [2:0] {
		SP_HOLD,
		SP_INC,
		SP_DEC,
		SP_DEC2,
		SP_CLEAR
	} fsa_spop_t;

	typedef enum logic [1:0] {
		PV_ZERO,
		PV_TOP,
		PV_CHAR
	} fsa_pvsel_t;

	typedef struct packed {
		logic              accept;
		logic              cap_ops;
		logic              wr_en;
		fsa_waddr_t        wr_addr;
		fsa_wsrc_t         wr_src;
		fsa_spop_t         sp_op;
		logic              res_load;
		logic [STS_W-1:0]  res_status;
		logic [KIND_W-1:0] res_kind;
		fsa_pvsel_t        res_pval;
		logic              div_start;
		logic              out_load;
	} fsa_cmd_t;

	typedef struct packed {
		logic sp_zero;
		logic sp_lt2;
		logic sp_full;
		logic top_zero;
		logic div_done;
	} fsa_stat_t;

endpackage

[sv/fsa_ram.sv]
module fsa_ram import fsa_pkg::*; #(
	parameter int WIDTH = DATA_W,
	parameter int DEPTH = STACK_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr_a,
	input  logic [AW-1:0]    rd_addr_b,
	output logic [WIDTH-1:0] rd_data_a,
	output logic [WIDTH-1:0] rd_data_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_a <= mem[rd_addr_a];
		rd_data_b <= mem[rd_addr_b];
	end

endmodule

[sv/fsa_div.sv]
`include "forth_stack_alu_unit_macros.svh"

module fsa_div import fsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] dividend,
	input  logic [DATA_W-1:0] divisor,
	output logic              done,
	output logic [DATA_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DATA_W);
	localparam logic [DATA_W-1:0] HALF = {1'b1, {(DATA_W-1){1'b0}}};

	logic              run_q;
	logic              fin_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DATA_W-1:0] rem_q;
	logic [DATA_W-1:0] qsh_q;
	logic [DATA_W-1:0] dvs_q;
	logic              neg_q;
	logic              ovf_q;
	logic [DATA_W-1:0] res_q;

	logic [DATA_W-1:0] abs_a;
	logic [DATA_W-1:0] abs_b;
	logic              ovf_d;
	logic [DATA_W:0]   trial;
	logic [DATA_W:0]   diff;
	logic              ge;
	logic [DATA_W-1:0] fin_res;

	assign abs_a = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
	assign abs_b = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
	// quotient of (|a| << FRAC_W) / |b| needs more than DATA_W bits
	assign ovf_d = (abs_a >> FRAC_W) >= abs_b;

	assign trial = {rem_q, qsh_q[DATA_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign ge    = ~diff[DATA_W];

	always_comb begin
		if (ovf_q) begin
			fin_res = neg_q ? Q_MIN : Q_MAX;
		end else if (neg_q) begin
			fin_res = (qsh_q > HALF) ? Q_MIN : (~qsh_q + 1'b1);
		end else begin
			fin_res = (qsh_q >= HALF) ? Q_MAX : qsh_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && cnt_q == '0) begin
				run_q <= 1'b0;
			end
			fin_q  <= run_q && cnt_q == '0;
			done_q <= fin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= abs_a >> FRAC_W;
			qsh_q <= abs_a << FRAC_W;
			dvs_q <= abs_b;
			neg_q <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
			ovf_q <= ovf_d;
			cnt_q <= CNT_W'(DATA_W - 1);
		end else if (run_q) begin
			rem_q <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
			qsh_q <= {qsh_q[DATA_W-2:0], ge};
			cnt_q <= cnt_q - 1'b1;
		end
		if (fin_q) begin
			res_q <= fin_res;
		end
	end

	assign done     = done_q;
	assign quotient = res_q;

	`FSA_ASSERT_NEXT(a_div_last_step, clk, arst_n, run_q && cnt_q == '0, fin_q, "divider missed its finishing cycle")

endmodule

[sv/fsa_datapath.sv]
`include "forth_stack_alu_unit_macros.svh"

module fsa_datapath import fsa_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  fsa_cmd_t          cmd,
	output fsa_stat_t         stat,
	input  logic [DATA_W-1:0] operand_value,
	output logic [STS_W-1:0]  status,
	output logic [KIND_W-1:0] print_kind,
	output logic [DATA_W-1:0] print_value,
	output logic [SD_W-1:0]   stack_depth
);

	localparam int SP_W = $clog2(STACK_DEPTH + 1);
	localparam int AW   = $clog2(STACK_DEPTH);
	localparam logic [2*DATA_W-1:0] MUL_RND = {{(2*DATA_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};
	localparam logic [DATA_W-1:0]   CHR_RND = {{(DATA_W-FRAC_W){1'b0}}, {FRAC_W{1'b1}}};

	function automatic logic [DATA_W-1:0] sat_wide(input logic [DATA_W:0] v);
		logic [DATA_W-1:0] r;
		if (v[DATA_W] != v[DATA_W-1]) begin
			r = v[DATA_W] ? Q_MIN : Q_MAX;
		end else begin
			r = v[DATA_W-1:0];
		end
		return r;
	endfunction

	logic [SP_W-1:0]   sp_q;
	logic [DATA_W-1:0] lit_q;
	logic signed [DATA_W-1:0]   x_q;
	logic signed [DATA_W-1:0]   y_q;
	logic signed [2*DATA_W-1:0] prod_q;
	logic [STS_W-1:0]  res_status_q;
	logic [KIND_W-1:0] res_kind_q;
	logic [DATA_W-1:0] res_pval_q;
	logic [STS_W-1:0]  out_status_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [DATA_W-1:0] out_pval_q;
	logic [SD_W-1:0]   out_depth_q;

	logic [SP_W-1:0]   ptr_m1;
	logic [SP_W-1:0]   ptr_m2;
	logic [SP_W-1:0]   wr_ptr;
	logic [DATA_W-1:0] rd_top;
	logic [DATA_W-1:0] rd_sec;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W:0]   sum_w;
	logic [DATA_W:0]   dif_w;
	logic signed [2*DATA_W-1:0] prod_adj;
	logic signed [2*DATA_W-1:0] mul_sh;
	logic              mul_fit;
	logic [DATA_W-1:0] mul_res;
	logic [DATA_W-1:0] chr_t;
	logic [DATA_W-1:0] char_code;
	logic [DATA_W-1:0] dep_val;
	logic              div_done;
	logic [DATA_W-1:0] div_res;

	assign ptr_m1 = sp_q - SP_W'(1);
	assign ptr_m2 = sp_q - SP_W'(2);

	always_comb begin
		case (cmd.wr_addr)
			ADDR_SP:  wr_ptr = sp_q;
			ADDR_SP1: wr_ptr = ptr_m1;
			default:  wr_ptr = ptr_m2;
		endcase
	end

	fsa_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STACK_DEPTH)
	) u_stack (
		.clk       (clk),
		.wr_en     (cmd.wr_en),
		.wr_addr   (wr_ptr[AW-1:0]),
		.wr_data   (wr_data),
		.rd_addr_a (ptr_m1[AW-1:0]),
		.rd_addr_b (ptr_m2[AW-1:0]),
		.rd_data_a (rd_top),
		.rd_data_b (rd_sec)
	);

	fsa_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (rd_sec),
		.divisor  (rd_top),
		.done     (div_done),
		.quotient (div_res)
	);

	// second entry is the left operand, top entry the right one
	assign sum_w = {rd_sec[DATA_W-1], rd_sec} + {rd_top[DATA_W-1], rd_top};
	assign dif_w = {rd_sec[DATA_W-1], rd_sec} - {rd_top[DATA_W-1], rd_top};

	// truncate the product toward zero, then drop the fraction
	assign prod_adj = prod_q + (prod_q[2*DATA_W-1] ? MUL_RND : '0);
	assign mul_sh   = prod_adj >>> FRAC_W;
	assign mul_fit  = (&mul_sh[2*DATA_W-1:DATA_W-1]) | ~(|mul_sh[2*DATA_W-1:DATA_W-1]);
	assign mul_res  = mul_fit ? mul_sh[DATA_W-1:0] : (mul_sh[2*DATA_W-1] ? Q_MIN : Q_MAX);

	assign chr_t     = rd_top + (rd_top[DATA_W-1] ? CHR_RND : '0);
	assign char_code = DATA_W'(chr_t[FRAC_W +: 8]);
	assign dep_val   = DATA_W'({sp_q, {FRAC_W{1'b0}}});

	always_comb begin
		case (cmd.wr_src)
			WS_LIT:   wr_data = lit_q;
			WS_TOP:   wr_data = rd_top;
			WS_SEC:   wr_data = rd_sec;
			WS_HELD:  wr_data = y_q;
			WS_ADD:   wr_data = sat_wide(sum_w);
			WS_SUB:   wr_data = sat_wide(dif_w);
			WS_MUL:   wr_data = mul_res;
			WS_DIV:   wr_data = div_res;
			WS_DEPTH: wr_data = dep_val;
			default:  wr_data = lit_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else begin
			case (cmd.sp_op)
				SP_INC:   sp_q <= sp_q + SP_W'(1);
				SP_DEC:   sp_q <= ptr_m1;
				SP_DEC2:  sp_q <= ptr_m2;
				SP_CLEAR: sp_q <= '0;
				default:  sp_q <= sp_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			lit_q <= operand_value;
		end
		if (cmd.cap_ops) begin
			x_q <= rd_sec;
			y_q <= rd_top;
		end
		prod_q <= x_q * y_q;
		if (cmd.res_load) begin
			res_status_q <= cmd.res_status;
			res_kind_q   <= cmd.res_kind;
			case (cmd.res_pval)
				PV_TOP:  res_pval_q <= rd_top;
				PV_CHAR: res_pval_q <= char_code;
				default: res_pval_q <= '0;
			endcase
		end
		if (cmd.out_load) begin
			out_status_q <= res_status_q;
			out_kind_q   <= res_kind_q;
			out_pval_q   <= res_pval_q;
			out_depth_q  <= SD_W'(sp_q);
		end
	end

	assign stat.sp_zero  = sp_q == '0;
	assign stat.sp_lt2   = sp_q < SP_W'(2);
	assign stat.sp_full  = sp_q >= SP_W'(STACK_DEPTH);
	assign stat.top_zero = rd_top == '0;
	assign stat.div_done = div_done;

	assign status      = out_status_q;
	assign print_kind  = out_kind_q;
	assign print_value = out_pval_q;
	assign stack_depth = out_depth_q;

	`FSA_ASSERT_ALWAYS(a_sp_in_range, clk, arst_n, sp_q <= SP_W'(STACK_DEPTH), "stack pointer beyond stack depth")
	`FSA_ASSERT_IMPLY(a_wr_in_range, clk, arst_n, cmd.wr_en, wr_ptr < SP_W'(STACK_DEPTH), "stack write outside the store")

endmodule

[sv/fsa_ctrl.sv]
`include "forth_stack_alu_unit_macros.svh"

module fsa_ctrl import fsa_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [FUNC_W-1:0] func,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  fsa_stat_t         stat,
	output fsa_cmd_t          cmd
);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_EXEC  = 7'b0000010,
		S_SWAP2 = 7'b0000100,
		S_MUL1  = 7'b0001000,
		S_MUL2  = 7'b0010000,
		S_DIV   = 7'b0100000,
		S_DONE  = 7'b1000000
	} ctrl_state_t;

	ctrl_state_t       st_q;
	ctrl_state_t       st_d;
	logic [FUNC_W-1:0] func_q;
	logic              m_tvalid_q;

	always_comb begin
		cmd  = '0;
		st_d = st_q;
		case (st_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					st_d       = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.cap_ops    = 1'b1;
				cmd.res_load   = 1'b1;
				cmd.res_status = STS_OK;
				cmd.res_kind   = PK_NONE;
				cmd.res_pval   = PV_ZERO;
				st_d           = S_DONE;
				case (func_q)
					FN_PUSH, FN_DEPTH: begin
						if (stat.sp_full) begin
							cmd.res_status = STS_OVF;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = ADDR_SP;
							cmd.wr_src  = (func_q == FN_PUSH) ? WS_LIT : WS_DEPTH;
							cmd.sp_op   = SP_INC;
						end
					end
					FN_DUP: begin
						if (stat.sp_zero) begin
							cmd.res_status = STS_UNF;
						end else if (stat.sp_full) begin
							cmd.res_status = STS_OVF;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = ADDR_SP;
							cmd.wr_src  = WS_TOP;
							cmd.sp_op   = SP_INC;
						end
					end
					FN_OVER: begin
						if (stat.sp_lt2) begin
							cmd.res_status = STS_UNF;
						end else if (stat.sp_full) begin
							cmd.res_status = STS_OVF;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = ADDR_SP;
							cmd.wr_src  = WS_SEC;
							cmd.sp_op   = SP_INC;
						end
					end
					FN_DROP: begin
						if (stat.sp_zero) begin
							cmd.res_status = STS_UNF;
						end else begin
							cmd.sp_op = SP_DEC;
						end
					end
					FN_SWAP: begin
						if (stat.sp_lt2) begin
							cmd.res_status = STS_UNF;
							cmd.sp_op      = SP_CLEAR;
						end else begin
							cmd.res_load = 1'b0;
							cmd.wr_en    = 1'b1;
							cmd.wr_addr  = ADDR_SP1;
							cmd.wr_src   = WS_SEC;
							st_d         = S_SWAP2;
						end
					end
					FN_ADD, FN_SUB: begin
						if (stat.sp_lt2) begin
							cmd.res_status = STS_UNF;
							cmd.sp_op      = SP_CLEAR;
						end else begin
							cmd.wr_en   = 1'b1;
							cmd.wr_addr = ADDR_SP2;
							cmd.wr_src  = (func_q == FN_ADD) ? WS_ADD : WS_SUB;
							cmd.sp_op   = SP_DEC;
						end
					end
					FN_MUL: begin
						if (stat.sp_lt2) begin
							cmd.res_status = STS_UNF;
							cmd.sp_op      = SP_CLEAR;
						end else begin
							cmd.res_load = 1'b0;
							st_d         = S_MUL1;
						end
					end
					FN_DIV: begin
						if (stat.sp_lt2) begin
							cmd.res_status = STS_UNF;
							cmd.sp_op      = SP_CLEAR;
						end else if (stat.top_zero) begin
							cmd.res_status = STS_DIVZ;
							cmd.sp_op      = SP_DEC2;
						end else begin
							cmd.res_load  = 1'b0;
							cmd.div_start = 1'b1;
							st_d          = S_DIV;
						end
					end
					FN_DOT, FN_EMIT: begin
						if (stat.sp_zero) begin
							cmd.res_status = STS_UNF;
						end else begin
							cmd.res_kind = (func_q == FN_DOT) ? PK_NUMBER : PK_CHAR;
							cmd.res_pval = (func_q == FN_DOT) ? PV_TOP : PV_CHAR;
							cmd.sp_op    = SP_DEC;
						end
					end
					FN_CLEAR: begin
						cmd.sp_op = SP_CLEAR;
					end
					FN_CR: begin
						cmd.res_kind = PK_LINE;
					end
					default: begin
						cmd.res_status = STS_OK;
					end
				endcase
			end
			S_SWAP2: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_addr    = ADDR_SP2;
				cmd.wr_src     = WS_HELD;
				cmd.res_load   = 1'b1;
				cmd.res_status = STS_OK;
				cmd.res_kind   = PK_NONE;
				cmd.res_pval   = PV_ZERO;
				st_d           = S_DONE;
			end
			S_MUL1: begin
				st_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.wr_en      = 1'b1;
				cmd.wr_addr    = ADDR_SP2;
				cmd.wr_src     = WS_MUL;
				cmd.sp_op      = SP_DEC;
				cmd.res_load   = 1'b1;
				cmd.res_status = STS_OK;
				cmd.res_kind   = PK_NONE;
				cmd.res_pval   = PV_ZERO;
				st_d           = S_DONE;
			end
			S_DIV: begin
				if (stat.div_done) begin
					cmd.wr_en      = 1'b1;
					cmd.wr_addr    = ADDR_SP2;
					cmd.wr_src     = WS_DIV;
					cmd.sp_op      = SP_DEC;
					cmd.res_load   = 1'b1;
					cmd.res_status = STS_OK;
					cmd.res_kind   = PK_NONE;
					cmd.res_pval   = PV_ZERO;
					st_d           = S_DONE;
				end
			end
			S_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					st_d         = S_IDLE;
				end
			end
			default: begin
				st_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cmd.out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= func;
		end
	end

	assign s_tready = st_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;

	`FSA_ASSERT_IMPLY(a_div_only_for_div, clk, arst_n, cmd.div_start, func_q == FN_DIV, "divider started for a word other than div")
	`FSA_ASSERT_IMPLY(a_push_needs_room, clk, arst_n, cmd.wr_en && cmd.wr_addr == ADDR_SP, !stat.sp_full, "push issued on a full stack")

endmodule

[sv/forth_stack_alu_unit.sv]
// Forth data stack unit: each request on the slave side carries one word (push, dup, drop,
// swap, over, add, sub, mul, div, dot, depth, clear, emit, cr) and produces exactly one
// result on the master side with a status, an optional print and the stack depth after
// the word. Values are signed Q16.16; add, sub, mul and div saturate, mul and div truncate
// toward zero. Words run one at a time: every word passes through a decode state and a
// result state before the next acceptance, swap adds a second store write, mul adds
// states for its registered operands and its registered product, and div waits on the
// radix-2 divider, which works out the quotient bits one per step, saturates the quotient
// and then has it written back. The stack lives in a simple dual-read memory with
// registered reads. The result register holds a finished result while the next request
// is taken; a word only stalls at its end if the previous result has not yet been
// collected. Stack entries need no initialisation after reset.
`include "forth_stack_alu_unit_macros.svh"

module forth_stack_alu_unit import fsa_pkg::*; #(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// slave side: one word per request
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] operand_value
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // [3:0] func
	// master side: one result per word
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [31:0] print_value, [38:32] stack_depth, [39] zero
	output logic [OUT_TUSER_W-1:0] m_tuser   // [1:0] status, [3:2] print_kind
);

	fsa_cmd_t          cmd;
	fsa_stat_t         stat;
	logic [STS_W-1:0]  status;
	logic [KIND_W-1:0] print_kind;
	logic [DATA_W-1:0] print_value;
	logic [SD_W-1:0]   stack_depth;

	// sequencing: decode the word, drive the store and divider, hold the result handshake
	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.func     (s_tuser[FUNC_W-1:0]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// stack store, pointer, arithmetic and result registers
	fsa_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.operand_value (s_tdata[DATA_W-1:0]),
		.status        (status),
		.print_kind    (print_kind),
		.print_value   (print_value),
		.stack_depth   (stack_depth)
	);

	// pack the result fields, lowest field first, pad to whole bytes
	assign m_tdata = {{(OUT_TDATA_W-SD_W-DATA_W){1'b0}}, stack_depth, print_value};
	assign m_tuser = {print_kind, status};

endmodule

[verif/forth_stack_alu_checker.sv]
`timescale 1ns / 1ps

// Scoreboard for the Forth stack unit: mirrors the data stack, predicts the one result
// of every accepted request and checks the results in order.
module forth_stack_alu_checker import fsa_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [31:0] operand_value
	input  logic [IN_TUSER_W-1:0]  s_tuser,  // [3:0] func
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,  // [31:0] print_value, [38:32] stack_depth, [39] zero
	input  logic [OUT_TUSER_W-1:0] m_tuser,  // [1:0] status, [3:2] print_kind
	output int                     fails,
	output int                     outstanding,
	output int                     words_seen,
	output int                     results_seen,
	output int                     overflows,
	output int                     underflows,
	output int                     div_zeros,
	output int                     prints
);

	typedef struct packed {
		logic [STS_W-1:0]  status;
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] pval;
		logic [SD_W-1:0]   depth;
	} word_result_t;

	logic signed [DATA_W-1:0] shadow_stack [STACK_DEPTH_DEF];
	int                       shadow_sp;
	word_result_t             expected_results [$];

	function automatic logic [DATA_W-1:0] clamp_q(input longint v);
		if (v > longint'(32'sh7FFF_FFFF))
			return Q_MAX;
		if (v < -longint'(64'sh8000_0000))
			return Q_MIN;
		return v[DATA_W-1:0];
	endfunction

	// Run one word on the shadow stack and return what the unit must answer.
	function automatic word_result_t execute_word(input logic [FUNC_W-1:0] f,
			input logic signed [DATA_W-1:0] lit);
		word_result_t r;
		logic signed [DATA_W-1:0] a, b;
		int need, whole;
		r = '0;
		case (f)
			FN_PUSH, FN_DEPTH: begin
				if (shadow_sp >= STACK_DEPTH_DEF) begin
					r.status = STS_OVF;
				end else begin
					shadow_stack[shadow_sp] = (f == FN_PUSH) ? lit : DATA_W'(shadow_sp * 65536);
					shadow_sp++;
				end
			end
			FN_DUP, FN_OVER: begin
				need = (f == FN_DUP) ? 1 : 2;
				if (shadow_sp < need) begin
					r.status = STS_UNF;
				end else if (shadow_sp >= STACK_DEPTH_DEF) begin
					r.status = STS_OVF;
				end else begin
					shadow_stack[shadow_sp] = shadow_stack[shadow_sp - need];
					shadow_sp++;
				end
			end
			FN_DROP: begin
				if (shadow_sp == 0)
					r.status = STS_UNF;
				else
					shadow_sp--;
			end
			FN_SWAP: begin
				if (shadow_sp < 2) begin
					// a lone top entry is popped and lost
					r.status = STS_UNF;
					shadow_sp = 0;
				end else begin
					a = shadow_stack[shadow_sp - 1];
					shadow_stack[shadow_sp - 1] = shadow_stack[shadow_sp - 2];
					shadow_stack[shadow_sp - 2] = a;
				end
			end
			FN_ADD, FN_SUB, FN_MUL, FN_DIV: begin
				if (shadow_sp < 2) begin
					r.status = STS_UNF;
					shadow_sp = 0;
				end else begin
					b = shadow_stack[shadow_sp - 1];
					a = shadow_stack[shadow_sp - 2];
					shadow_sp -= 2;
					if (f == FN_DIV && b == 0) begin
						r.status = STS_DIVZ;
					end else begin
						case (f)
							FN_ADD: shadow_stack[shadow_sp] = clamp_q(longint'(a) + longint'(b));
							FN_SUB: shadow_stack[shadow_sp] = clamp_q(longint'(a) - longint'(b));
							FN_MUL: shadow_stack[shadow_sp] =
								clamp_q((longint'(a) * longint'(b)) / 65536);
							default: shadow_stack[shadow_sp] =
								clamp_q((longint'(a) * 65536) / longint'(b));
						endcase
						shadow_sp++;
					end
				end
			end
			FN_DOT, FN_EMIT: begin
				if (shadow_sp == 0) begin
					r.status = STS_UNF;
				end else begin
					shadow_sp--;
					a = shadow_stack[shadow_sp];
					if (f == FN_DOT) begin
						r.kind = PK_NUMBER;
						r.pval = a;
					end else begin
						// integer part, truncated toward zero, low byte only
						whole = int'(a) / 65536;
						r.kind = PK_CHAR;
						r.pval = {24'd0, whole[7:0]};
					end
				end
			end
			FN_CLEAR: shadow_sp = 0;
			FN_CR: r.kind = PK_LINE;
			default: ;
		endcase
		r.depth = SD_W'(shadow_sp);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_result_t got, want;
		if (!arst_n) begin
			shadow_sp = 0;
			expected_results.delete();
			fails <= 0;
			outstanding <= 0;
			words_seen <= 0;
			results_seen <= 0;
			overflows <= 0;
			underflows <= 0;
			div_zeros <= 0;
			prints <= 0;
		end else begin
			// a result can never belong to the request taken on the same edge
			if (m_tvalid && m_tready) begin
				got = {m_tuser[1:0], m_tuser[3:2], m_tdata[31:0], m_tdata[38:32]};
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					fails <= fails + 1;
					if (fails < 10)
						$display("[%0t] unexpected result: sts=%0d kind=%0d val=%h depth=%0d",
							$realtime, got.status, got.kind, got.pval, got.depth);
				end else begin
					want = expected_results.pop_front();
					if (got !== want || m_tdata[39] !== 1'b0) begin
						fails <= fails + 1;
						if (fails < 10) begin
							$display("[%0t] mismatch, expected/actual:", $realtime);
							$display("  sts %0d/%0d kind %0d/%0d val %h/%h depth %0d/%0d pad %b",
								want.status, got.status, want.kind, got.kind,
								want.pval, got.pval, want.depth, got.depth, m_tdata[39]);
						end
					end
					if (want.status == STS_OVF) overflows <= overflows + 1;
					if (want.status == STS_UNF) underflows <= underflows + 1;
					if (want.status == STS_DIVZ) div_zeros <= div_zeros + 1;
					if (want.kind != PK_NONE) prints <= prints + 1;
				end
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(execute_word(s_tuser, s_tdata));
				words_seen <= words_seen + 1;
			end
			outstanding <= expected_results.size();
		end
	end

endmodule

[verif/tb_forth_stack_alu_unit.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for the Forth stack unit. A short directed sequence walks every
// word and the awkward corners (empty and shallow stacks, saturation, zero divisor, emit
// of a negative fraction, unused codes); the random part then mixes well-formed push/op
// sequences, full-stack fills and plain noise. All checking lives in the checker.
module tb_forth_stack_alu_unit;
	import fsa_pkg::*;

	localparam int RANDOM_WORDS = 750;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;  // [31:0] operand_value
	logic [IN_TUSER_W-1:0]  s_tuser;  // [3:0] func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;  // [31:0] print_value, [38:32] stack_depth, [39] zero
	logic [OUT_TUSER_W-1:0] m_tuser;  // [1:0] status, [3:2] print_kind

	int fails, outstanding, words_seen, results_seen;
	int overflows, underflows, div_zeros, prints;

	int burst_left;     // requests left in the current sender burst
	int random_sent;    // random requests that the unit acts on
	int rx_mode;
	int rx_run_left;

	forth_stack_alu_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	forth_stack_alu_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.s_tuser      (s_tuser),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.m_tuser      (m_tuser),
		.fails        (fails),
		.outstanding  (outstanding),
		.words_seen   (words_seen),
		.results_seen (results_seen),
		.overflows    (overflows),
		.underflows   (underflows),
		.div_zeros    (div_zeros),
		.prints       (prints)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Give up well past the slowest legal run (every word a divide, long stalls both sides).
	initial begin
		#10_000_000;
		$display("forth_stack_alu_unit verification failed");
		$finish;
	end

	// Receiver: switch between always ready, random ready and long stalls, each for a
	// random stretch, so back-pressure lands on every phase of a word.
	always @(negedge clk) begin
		if (rx_run_left == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_run_left = $urandom_range(4, 60);
		end
		rx_run_left--;
		case (rx_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 9) < 7);
			2: m_tready <= ($urandom_range(0, 9) < 3);
			default: m_tready <= 1'b0;
		endcase
	end

	// Q16.16 operand: weighted towards extremes, zero, whole numbers and printable codes.
	function automatic logic [DATA_W-1:0] pick_q();
		case ($urandom_range(0, 9))
			0, 1: return $urandom;
			2: return Q_MAX;
			3: return Q_MIN;
			4: return '0;
			5: return ($urandom_range(0, 1)) ? 32'h0001_0000 : 32'hFFFF_0000;
			6: return DATA_W'(($urandom_range(0, 400) - 200) * 65536);
			7: return {8'd0, 8'($urandom_range(0, 255)), 16'($urandom)};
			default: return DATA_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
		endcase
	endfunction

	// Present one request, sometimes idling first when the burst is used up; hold until taken.
	task automatic send_word(input logic [FUNC_W-1:0] f, input logic [DATA_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= v;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		if (f <= FN_CR)
			random_sent++;
	endtask

	task automatic send_binary_op();
		case ($urandom_range(0, 3))
			0: send_word(FN_ADD, $urandom);
			1: send_word(FN_SUB, $urandom);
			2: send_word(FN_MUL, $urandom);
			default: send_word(FN_DIV, $urandom);
		endcase
	endtask

	// Fill the stack to the brim, knock on the full stack with every growing word, then
	// work the deep end a little and usually empty it again.
	task automatic fill_stack();
		send_word(FN_CLEAR, $urandom);
		send_word(FN_PUSH, pick_q());
		send_word(FN_PUSH, pick_q());
		repeat (STACK_DEPTH_DEF - 2) begin
			case ($urandom_range(0, 5))
				0: send_word(FN_DUP, $urandom);
				1: send_word(FN_OVER, $urandom);
				2: send_word(FN_DEPTH, $urandom);
				default: send_word(FN_PUSH, pick_q());
			endcase
		end
		send_word(FN_PUSH, pick_q());
		send_word(FN_DUP, $urandom);
		send_word(FN_OVER, $urandom);
		send_word(FN_DEPTH, $urandom);
		send_word(FN_SWAP, $urandom);
		send_binary_op();
		send_word(FN_DOT, $urandom);
		if ($urandom_range(0, 2) != 0)
			send_word(FN_CLEAR, $urandom);
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		burst_left  = 0;
		random_sent = 0;
		rx_mode     = 0;
		rx_run_left = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: empty-stack errors, shallow dup/over/swap, saturation, zero divisor,
		// emit of a negative fraction, depth on an empty stack, unused codes, clear.
		send_word(FN_CR, '0);
		send_word(FN_DROP, '0);
		send_word(FN_DOT, '0);
		send_word(FN_EMIT, '1);
		send_word(FN_DUP, '0);
		send_word(FN_PUSH, Q_MAX);
		send_word(FN_OVER, '0);
		send_word(FN_SWAP, '0);         // one entry: popped and lost
		send_word(FN_PUSH, Q_MAX);
		send_word(FN_DUP, '0);
		send_word(FN_ADD, '0);          // saturate high
		send_word(FN_PUSH, Q_MIN);
		send_word(FN_SWAP, '0);
		send_word(FN_OVER, '0);
		send_word(FN_SUB, '0);          // max minus min, saturate high
		send_word(FN_MUL, '0);          // saturate low
		send_word(FN_PUSH, '0);
		send_word(FN_DIV, '0);          // zero divisor, both operands lost
		send_word(FN_PUSH, 32'hFFBE_8000);
		send_word(FN_EMIT, '0);         // -65.5 truncates to -65
		send_word(FN_DEPTH, '0);
		send_word(FN_PUSH, Q_MIN);
		send_word(FN_PUSH, 32'hFFFF_0000);
		send_word(FN_DIV, '0);          // min over minus one, saturate high
		send_word(FN_DOT, '0);
		send_word(4'd14, 32'h1234_5678);
		send_word(4'd15, '1);
		send_word(FN_CLEAR, '0);

		// Random: mostly well-formed sequences with random content, the rest noise.
		random_sent = 0;
		fill_stack();
		while (random_sent < RANDOM_WORDS) begin
			case ($urandom_range(0, 199))
				0: fill_stack();
				1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16, 17, 18, 19, 20: begin
					send_word(FN_PUSH, pick_q());
					case ($urandom_range(0, 3))
						0: send_word(FN_EMIT, $urandom);
						1: send_word(FN_DOT, $urandom);
						2: begin
							send_word(FN_DUP, $urandom);
							send_word(FN_MUL, $urandom);
						end
						default: send_word(FN_CR, $urandom);
					endcase
				end
				default: begin
					if ($urandom_range(0, 1) == 0) begin
						send_word(FN_PUSH, pick_q());
						send_word(FN_PUSH, pick_q());
						if ($urandom_range(0, 3) == 0)
							send_word(FN_SWAP, $urandom);
						send_binary_op();
						if ($urandom_range(0, 1) == 0)
							send_word(FN_DOT, $urandom);
					end else begin
						// noise: any code, unused ones included
						send_word(4'($urandom_range(0, 15)), pick_q());
					end
				end
			endcase
		end
		@(negedge clk);
		s_tvalid <= 1'b0;

		// Drain, then let the clock run on to catch anything stray.
		while (outstanding != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);

		$display("%0d words, %0d results checked; %0d overflow, %0d underflow, %0d zero divide",
			words_seen, results_seen, overflows, underflows, div_zeros);
		$display("%0d results printed something; %0d mismatches counted", prints, fails);
		if (fails == 0)
			$display("forth_stack_alu_unit verification clean");
		else
			$display("forth_stack_alu_unit verification failed");
		$finish;
	end

endmodule
